// ----- rtl/core/pcs_pkg.sv -----
package pcs_pkg;

    // Character codes seen by the scanner
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // One input byte can cause up to four results when it closes a text
    localparam int MAX_RES   = 4;
    localparam int RES_CNT_W = 3;
    localparam int RES_IDX_W = 2;

    typedef enum logic [2:0] {
        MODE_CODE      = 3'd0,
        MODE_STRING    = 3'd1,
        MODE_LINE      = 3'd2,
        MODE_BRACE     = 3'd3,
        MODE_PAREN     = 3'd4,
        MODE_PAREN_IN  = 3'd5,
        MODE_PAREN_OUT = 3'd6
    } t_scan_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       unclosed_comment;
    } t_out_req;

    // Outcome of judging one byte against its lookahead
    typedef struct packed {
        t_scan_mode mode;
        logic       skip;
        logic       emit;
        logic [7:0] ch;
    } t_judge;

    function automatic t_judge judge(t_scan_mode mode, logic skip,
                                     logic [7:0] h, logic [7:0] la);
        t_judge r;
        r.mode = mode;
        r.skip = 1'b0;
        r.emit = 1'b0;
        r.ch   = h;
        if (skip) begin
            // second apostrophe of a doubled pair
            r.emit = 1'b1;
        end else begin
            unique case (mode)
                MODE_STRING: begin
                    r.emit = 1'b1;
                    if (h == CH_APOS) begin
                        if (la == CH_APOS) r.skip = 1'b1;
                        else               r.mode = MODE_CODE;
                    end
                end
                MODE_LINE: begin
                    if (h == CH_NL) begin
                        r.mode = MODE_CODE;
                        r.emit = 1'b1;
                        r.ch   = CH_SPACE;
                    end
                end
                MODE_BRACE: begin
                    if (h == CH_RBRACE) begin
                        r.mode = MODE_CODE;
                        r.emit = 1'b1;
                        r.ch   = CH_SPACE;
                    end
                end
                MODE_PAREN_IN: begin
                    // star of the opener cannot start the closer
                    r.mode = MODE_PAREN;
                end
                MODE_PAREN: begin
                    if (h == CH_STAR && la == CH_RPAREN) begin
                        r.mode = MODE_PAREN_OUT;
                        r.emit = 1'b1;
                        r.ch   = CH_SPACE;
                    end
                end
                MODE_PAREN_OUT: begin
                    // closing paren is swallowed
                    r.mode = MODE_CODE;
                end
                MODE_CODE: begin
                    priority if (h == CH_LBRACE) begin
                        r.mode = MODE_BRACE;
                    end else if (h == CH_LPAREN && la == CH_STAR) begin
                        r.mode = MODE_PAREN_IN;
                    end else if (h == CH_SLASH && la == CH_SLASH) begin
                        r.mode = MODE_LINE;
                    end else begin
                        r.emit = 1'b1;
                        if (h == CH_APOS) r.mode = MODE_STRING;
                    end
                end
                default: begin
                    r.mode = MODE_CODE;
                end
            endcase
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/pcs_stream_if.sv -----
interface pcs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/pcs_scan.sv -----
module pcs_scan (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  pcs_pkg::t_in_req                     i_req,
    output pcs_pkg::t_out_req [pcs_pkg::MAX_RES-1:0] o_res,
    output logic [pcs_pkg::RES_CNT_W-1:0]        o_count
);
    import pcs_pkg::*;

    t_scan_mode r_mode, n_mode;
    logic       r_skip, n_skip;
    logic       r_held_valid, n_held_valid;
    logic [7:0] r_held, n_held;

    t_judge                   w_j0, w_j1, w_j2;
    logic                     w_unc;
    t_out_req [MAX_RES-1:0]   w_item;
    logic [MAX_RES-1:0]       w_item_vld;
    t_out_req [MAX_RES-1:0]   w_res;
    logic [RES_CNT_W-1:0]     w_cnt;

    // Judge held byte, then on end of text the last byte and the implied newline
    always_comb begin
        if (r_held_valid) begin
            w_j0 = judge(r_mode, r_skip, r_held, i_req.in_byte);
        end else begin
            w_j0.mode = r_mode;
            w_j0.skip = r_skip;
            w_j0.emit = 1'b0;
            w_j0.ch   = i_req.in_byte;
        end
        w_j1  = judge(w_j0.mode, w_j0.skip, i_req.in_byte, CH_NL);
        w_j2  = judge(w_j1.mode, w_j1.skip, CH_NL, CH_SPACE);
        w_unc = (w_j2.mode == MODE_BRACE) || (w_j2.mode == MODE_PAREN) ||
                (w_j2.mode == MODE_PAREN_IN);
    end

    // Candidate results in order, then packed to the front
    always_comb begin
        w_item[0]  = '{out_byte: w_j0.ch, out_last: 1'b0, unclosed_comment: 1'b0};
        w_item[1]  = '{out_byte: w_j1.ch, out_last: 1'b0, unclosed_comment: 1'b0};
        w_item[2]  = '{out_byte: w_j2.ch, out_last: 1'b0, unclosed_comment: 1'b0};
        w_item[3]  = '{out_byte: CH_SPACE, out_last: 1'b1, unclosed_comment: w_unc};
        w_item_vld = {i_req.in_last, i_req.in_last & w_j2.emit,
                      i_req.in_last & w_j1.emit, w_j0.emit};
        w_res = '0;
        w_cnt = '0;
        for (int k = 0; k < MAX_RES; k++) begin
            if (w_item_vld[k]) begin
                w_res[w_cnt[RES_IDX_W-1:0]] = w_item[k];
                w_cnt = w_cnt + 1'b1;
            end
        end
    end

    assign o_res   = w_res;
    assign o_count = w_cnt;

    // Scanner state: end of text returns everything to reset
    always_comb begin
        n_mode       = r_mode;
        n_skip       = r_skip;
        n_held_valid = r_held_valid;
        n_held       = r_held;
        if (i_accept) begin
            if (i_req.in_last) begin
                n_mode       = MODE_CODE;
                n_skip       = 1'b0;
                n_held_valid = 1'b0;
            end else begin
                n_mode       = w_j0.mode;
                n_skip       = w_j0.skip;
                n_held_valid = 1'b1;
                n_held       = i_req.in_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_CODE;
            r_skip       <= 1'b0;
            r_held_valid <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_skip       <= n_skip;
            r_held_valid <= n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

`ifndef ASSERT_OFF
    // A byte that does not end the text yields at most one result
    a_single_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_req.in_last) |-> (w_cnt <= 3'd1))
        else $error("more than one result for a mid-text byte");

    // End of text always yields a final flagged result
    a_last_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_req.in_last) |->
            (w_cnt != 3'd0) && w_res[w_cnt[RES_IDX_W-1:0] - 1'b1].out_last)
        else $error("end of text without final result");

    // After end of text the lookahead is empty
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_req.in_last) |=> (!r_held_valid && !r_skip))
        else $error("scanner not restarted after end of text");
`endif

endmodule

// ----- rtl/core/pcs_outq.sv -----
module pcs_outq (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  pcs_pkg::t_out_req [pcs_pkg::MAX_RES-1:0] i_res,
    input  logic [pcs_pkg::RES_CNT_W-1:0]        i_count,
    output logic                                 o_in_ready,
    pcs_stream_if.source                         o_out
);
    import pcs_pkg::*;

    t_out_req [MAX_RES-1:0] r_slot, n_slot;
    logic [RES_CNT_W-1:0]   r_count, n_count;
    logic                   w_pop;

    assign w_pop      = (r_count != '0) && o_out.ready;
    // take a new request once the queue drains this cycle
    assign o_in_ready = (r_count == '0) || ((r_count == 3'd1) && o_out.ready);

    // Load on push, shift down on pop
    always_comb begin
        n_slot  = r_slot;
        n_count = r_count;
        if (i_push) begin
            n_slot  = i_res;
            n_count = i_count;
        end else if (w_pop) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                n_slot[k] = r_slot[k+1];
            end
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_out.valid = (r_count != '0);
    assign o_out.data  = r_slot[0];

`ifndef ASSERT_OFF
    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> ((r_count == 3'd0) || ((r_count == 3'd1) && w_pop)))
        else $error("push over pending results");

    // Fill never exceeds the slots
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("queue overfilled");

    // A pop without push drops exactly one entry
    a_pop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !i_push) |=> (r_count == $past(r_count) - 3'd1))
        else $error("queue count slipped");
`endif

endmodule

// ----- rtl/core/pascal_comment_stripper.sv -----
// Channel  Dir  Modport  Payload
// i_in     in   sink     in_byte[7:0], in_last
// o_out    out  source   out_byte[7:0], out_last, unclosed_comment
//
// One request is taken per cycle while i_in.ready is high; results next cycle.
// A mid-text byte gives zero or one result, an end-of-text byte up to four,
// which leave the 4-entry queue one per cycle while o_out.ready is high.
// i_in.ready is high when the queue is empty or its last entry leaves now.
// Reset (synchronous, active low) empties the queue and clears the scanner.
module pascal_comment_stripper (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcs_stream_if.sink    i_in,
    pcs_stream_if.source  o_out
);
    import pcs_pkg::*;

    logic                   w_in_ready;
    logic                   w_accept;
    t_out_req [MAX_RES-1:0] w_res;
    logic [RES_CNT_W-1:0]   w_count;

    assign i_in.ready = w_in_ready;
    assign w_accept   = i_in.valid && w_in_ready;

    // Per-byte decision
    pcs_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_req    (i_in.data),
        .o_res    (w_res),
        .o_count  (w_count)
    );

    // Result queue
    pcs_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_accept),
        .i_res      (w_res),
        .i_count    (w_count),
        .o_in_ready (w_in_ready),
        .o_out      (o_out)
    );

endmodule
